FILE: design/c3vb_pkg.sv
// Package for the 3x3 two-channel convolution stream block.
// Holds widths, register index codes and the column and control types.
// Used by every module under design/.
package c3vb_pkg;

  localparam int MAX_WIDTH = 32;
  localparam int WIN = 3;

  localparam int PIX_W = 16;
  localparam int COEF_W = 16;
  localparam int PROD_W = PIX_W + COEF_W;
  localparam int PART_W = PROD_W + 3;
  localparam int TOTAL_W = PART_W + 2;
  localparam int VALUE_W = 40;
  localparam int SUM_W = VALUE_W + 1;
  localparam int COORD_W = 5;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = COL_W + 1;
  localparam int LW_W = 6;

  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W = 3;

  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int ROW_LSB = VALUE_W;
  localparam int COL_LSB = VALUE_W + COORD_W;
  localparam int PAD_W = OUT_TDATA_W - VALUE_W - 2 * COORD_W;
  localparam int MAX_COORD = MAX_WIDTH - WIN;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_A0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd7;

  localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 6'd28;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COEF_W-1:0] coef_t;

  typedef struct packed {
    pix_t [WIN-1:0] a;
    pix_t [WIN-1:0] b;
  } pix_col_t;

  typedef struct packed {
    coef_t [WIN-1:0] a;
    coef_t [WIN-1:0] b;
  } coef_col_t;

  typedef struct packed {
    logic shift;
    logic step;
  } cell_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic last;
  } tag_t;

endpackage

FILE: design/c3vb_line_store.sv
// Two line stores of one channel, indexed by column.
// Depends on c3vb_pkg.
module c3vb_line_store (
  input  logic                     clk,
  input  logic                     wr,
  input  logic [c3vb_pkg::COL_W-1:0] col,
  input  c3vb_pkg::pix_t           pixel,
  output c3vb_pkg::pix_t           rd_older,
  output c3vb_pkg::pix_t           rd_newer
);

  c3vb_pkg::pix_t newer_row [c3vb_pkg::MAX_WIDTH];
  c3vb_pkg::pix_t older_row [c3vb_pkg::MAX_WIDTH];

  assign rd_older = older_row[col];
  assign rd_newer = newer_row[col];

  always_ff @(posedge clk) begin
    if (wr) begin
      older_row[col] <= newer_row[col];
      newer_row[col] <= pixel;
    end
  end

endmodule

FILE: design/c3vb_tap_cell.sv
// One window column cell: holds a column of both channels, hands it to the
// next older cell and forms its registered share of the dot product.
// Depends on c3vb_pkg.
module c3vb_tap_cell (
  input  logic                              clk,
  input  c3vb_pkg::cell_ctl_t               ctl,
  input  c3vb_pkg::pix_col_t                col_in,
  input  c3vb_pkg::coef_col_t               coef,
  output c3vb_pkg::pix_col_t                col_out,
  output logic signed [c3vb_pkg::PART_W-1:0] partial
);

  c3vb_pkg::pix_col_t held;
  logic signed [c3vb_pkg::PROD_W-1:0] prod_a [c3vb_pkg::WIN];
  logic signed [c3vb_pkg::PROD_W-1:0] prod_b [c3vb_pkg::WIN];
  logic signed [c3vb_pkg::PART_W-1:0] partial_next;

  assign col_out = held;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      held <= col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      for (int m = 0; m < c3vb_pkg::WIN; m++) begin
        prod_a[m] <= $signed(held.a[m]) * $signed(coef.a[m]);
        prod_b[m] <= $signed(held.b[m]) * $signed(coef.b[m]);
      end
    end
  end

  always_comb begin
    partial_next = '0;
    for (int m = 0; m < c3vb_pkg::WIN; m++) begin
      partial_next = partial_next + c3vb_pkg::PART_W'(prod_a[m])
                     + c3vb_pkg::PART_W'(prod_b[m]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      partial <= partial_next;
    end
  end

endmodule

FILE: design/conv3x3_valid_bias_stream.sv
// An accepted beat passes the window, product, cell-sum and total registers,
// then the output register that raises m_tvalid. Throughput: one beat per cycle
// on both sides while the skid register is empty; a two-entry output stage
// (output register and skid register) lets input continue while a result waits.
// Reset: synchronous; clears row and column counters, pipeline and output
// valids, and the registers to their defaults (coefficients and bias zero, width 28).
module conv3x3_valid_bias_stream (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0: pixel_a[15:0], pixel_b[31:16].
  input  logic [c3vb_pkg::IN_TDATA_W-1:0]     s_tdata,
  // Fields from bit 0: frame_start[0].
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // Fields from bit 0: conv_value[39:0], out_row[44:40], out_col[49:45], zero fill.
  output logic [c3vb_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [c3vb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c3vb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PIPE_DEPTH = 4;
  localparam int CNT_W = c3vb_pkg::CNT_W;
  localparam int SUM_W = c3vb_pkg::SUM_W;
  localparam int VALUE_W = c3vb_pkg::VALUE_W;

  logic [c3vb_pkg::CFG_DATA_W-1:0] coef_a [c3vb_pkg::WIN];
  logic [c3vb_pkg::CFG_DATA_W-1:0] coef_b [c3vb_pkg::WIN];
  logic [VALUE_W-1:0] bias;
  logic [c3vb_pkg::LW_W-1:0] line_width;

  logic [c3vb_pkg::COL_W-1:0] row_count;
  logic [c3vb_pkg::COL_W-1:0] col_count;

  logic advance;
  logic accept;
  logic [CNT_W-1:0] w, r0, c0, r1, c1, r, c, c_inc, r_inc, row_next, col_next;
  logic full;
  c3vb_pkg::tag_t tag;

  c3vb_pkg::pix_t older_a, newer_a, older_b, newer_b;
  c3vb_pkg::pix_col_t new_col;
  c3vb_pkg::pix_col_t cell_col [c3vb_pkg::WIN];
  c3vb_pkg::coef_col_t coef_col [c3vb_pkg::WIN];
  logic signed [c3vb_pkg::PART_W-1:0] partial [c3vb_pkg::WIN];
  c3vb_pkg::cell_ctl_t ctl;

  logic [PIPE_DEPTH-1:0] valid_pipe;
  c3vb_pkg::tag_t tag_pipe [PIPE_DEPTH];
  logic signed [c3vb_pkg::TOTAL_W-1:0] total;
  logic signed [SUM_W-1:0] sum;
  logic [VALUE_W-1:0] result;
  logic incoming;

  logic [VALUE_W-1:0] out_value, skid_value;
  c3vb_pkg::tag_t out_tag, skid_tag;
  logic skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < c3vb_pkg::WIN; i++) begin
        coef_a[i] <= '0;
        coef_b[i] <= '0;
      end
      bias <= '0;
      line_width <= c3vb_pkg::LINE_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        c3vb_pkg::REG_COEF_A0: coef_a[0] <= cfg_data;
        c3vb_pkg::REG_COEF_A1: coef_a[1] <= cfg_data;
        c3vb_pkg::REG_COEF_A2: coef_a[2] <= cfg_data;
        c3vb_pkg::REG_COEF_B0: coef_b[0] <= cfg_data;
        c3vb_pkg::REG_COEF_B1: coef_b[1] <= cfg_data;
        c3vb_pkg::REG_COEF_B2: coef_b[2] <= cfg_data;
        c3vb_pkg::REG_BIAS: bias <= cfg_data[VALUE_W-1:0];
        c3vb_pkg::REG_LINE_WIDTH: line_width <= cfg_data[c3vb_pkg::LW_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance = !skid_valid;
  assign s_tready = advance;
  assign accept = s_tvalid && advance;

  always_comb begin
    if (CNT_W'(line_width) < CNT_W'(c3vb_pkg::WIN)) begin
      w = CNT_W'(c3vb_pkg::WIN);
    end else if (CNT_W'(line_width) > CNT_W'(c3vb_pkg::MAX_WIDTH)) begin
      w = CNT_W'(c3vb_pkg::MAX_WIDTH);
    end else begin
      w = CNT_W'(line_width);
    end
    r0 = s_tuser ? '0 : CNT_W'(row_count);
    c0 = s_tuser ? '0 : CNT_W'(col_count);
    if (c0 >= w) begin
      c1 = '0;
      r1 = r0 + CNT_W'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r = (r1 >= w) ? '0 : r1;
    c = c1;
    c_inc = c + CNT_W'(1);
    r_inc = r + CNT_W'(1);
    if (c_inc >= w) begin
      col_next = '0;
      row_next = (r_inc >= w) ? '0 : r_inc;
    end else begin
      col_next = c_inc;
      row_next = r;
    end
    full = (r >= CNT_W'(c3vb_pkg::WIN - 1)) && (c >= CNT_W'(c3vb_pkg::WIN - 1));
    tag.row = c3vb_pkg::COORD_W'(r - CNT_W'(c3vb_pkg::WIN - 1));
    tag.col = c3vb_pkg::COORD_W'(c - CNT_W'(c3vb_pkg::WIN - 1));
    tag.last = (r == w - CNT_W'(1)) && (c == w - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_next[c3vb_pkg::COL_W-1:0];
      col_count <= col_next[c3vb_pkg::COL_W-1:0];
    end
  end

  c3vb_line_store u_store_a (
    .clk      (clk),
    .wr       (accept),
    .col      (c[c3vb_pkg::COL_W-1:0]),
    .pixel    (s_tdata[c3vb_pkg::PIX_W-1:0]),
    .rd_older (older_a),
    .rd_newer (newer_a)
  );

  c3vb_line_store u_store_b (
    .clk      (clk),
    .wr       (accept),
    .col      (c[c3vb_pkg::COL_W-1:0]),
    .pixel    (s_tdata[2*c3vb_pkg::PIX_W-1:c3vb_pkg::PIX_W]),
    .rd_older (older_b),
    .rd_newer (newer_b)
  );

  always_comb begin
    new_col.a[0] = older_a;
    new_col.a[1] = newer_a;
    new_col.a[2] = s_tdata[c3vb_pkg::PIX_W-1:0];
    new_col.b[0] = older_b;
    new_col.b[1] = newer_b;
    new_col.b[2] = s_tdata[2*c3vb_pkg::PIX_W-1:c3vb_pkg::PIX_W];
  end

  assign ctl.shift = accept;
  assign ctl.step = advance;

  for (genvar k = 0; k < c3vb_pkg::WIN; k++) begin : g_cell
    c3vb_pkg::pix_col_t col_feed;

    always_comb begin
      for (int m = 0; m < c3vb_pkg::WIN; m++) begin
        coef_col[k].a[m] = coef_a[m][c3vb_pkg::COEF_W*k +: c3vb_pkg::COEF_W];
        coef_col[k].b[m] = coef_b[m][c3vb_pkg::COEF_W*k +: c3vb_pkg::COEF_W];
      end
    end

    if (k == c3vb_pkg::WIN - 1) begin : g_newest
      assign col_feed = new_col;
    end else begin : g_older
      assign col_feed = cell_col[k+1];
    end

    c3vb_tap_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .col_in  (col_feed),
      .coef    (coef_col[k]),
      .col_out (cell_col[k]),
      .partial (partial[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (advance) begin
      valid_pipe <= {valid_pipe[PIPE_DEPTH-2:0], accept && full};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_pipe[0] <= tag;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        tag_pipe[i] <= tag_pipe[i-1];
      end
      total <= c3vb_pkg::TOTAL_W'(partial[0]) + c3vb_pkg::TOTAL_W'(partial[1])
               + c3vb_pkg::TOTAL_W'(partial[2]);
    end
  end

  always_comb begin
    sum = SUM_W'(total) + SUM_W'($signed(bias));
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      result = sum[SUM_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      result = sum[VALUE_W-1:0];
    end
  end

  assign incoming = valid_pipe[PIPE_DEPTH-1] && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= incoming;
      end
    end else if (incoming) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        out_value <= skid_value;
        out_tag <= skid_tag;
      end else begin
        out_value <= result;
        out_tag <= tag_pipe[PIPE_DEPTH-1];
      end
    end else if (incoming) begin
      skid_value <= result;
      skid_tag <= tag_pipe[PIPE_DEPTH-1];
    end
  end

  assign m_tdata = {{c3vb_pkg::PAD_W{1'b0}}, out_tag.col, out_tag.row, out_value};
  assign m_tlast = out_tag.last;

endmodule

FILE: design/c3vb_checker.sv
// Port-level checks for the convolution stream block, bound to its top level.
// Depends on c3vb_pkg and conv3x3_valid_bias_stream.
module c3vb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [c3vb_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                              m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Output beat changed while stalled.");

  a_ready_only_blocked_by_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("Input stalled with no result waiting.");

  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[c3vb_pkg::ROW_LSB +: c3vb_pkg::COORD_W]
                  <= c3vb_pkg::COORD_W'(c3vb_pkg::MAX_COORD))
             && (m_tdata[c3vb_pkg::COL_LSB +: c3vb_pkg::COORD_W]
                  <= c3vb_pkg::COORD_W'(c3vb_pkg::MAX_COORD)))
    else $error("Output coordinate out of range.");

  a_last_on_corner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[c3vb_pkg::ROW_LSB +: c3vb_pkg::COORD_W]
                            == m_tdata[c3vb_pkg::COL_LSB +: c3vb_pkg::COORD_W])
    else $error("Last beat not on the bottom-right window.");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output valid after reset.");

endmodule

bind conv3x3_valid_bias_stream c3vb_checker u_c3vb_checker (.*);

FILE: verif/conv3x3_valid_bias_stream_tb.sv
// Self-checking testbench for the two-channel 3x3 valid convolution stream block.
// A local model of line stores, windows and counters predicts each result beat;
// depends on c3vb_pkg and the conv3x3_valid_bias_stream top level.
`timescale 1ns / 100ps

module conv3x3_valid_bias_stream_tb;
  import c3vb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP = 200;
  localparam int RANDOM_ITEMS = 650;
  localparam longint SUM_MAX = (longint'(1) <<< (VALUE_W - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } conv_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  pix_t               line_mem [2][2*MAX_WIDTH] = '{default: '0};
  pix_t               window [2][WIN][WIN] = '{default: '0};
  coef_t              coefs [2][WIN][WIN] = '{default: '0};
  logic [VALUE_W-1:0] bias_q = '0;
  logic [LW_W-1:0]    width_q = LINE_WIDTH_RESET;
  int                 row_cnt = 0;
  int                 col_cnt = 0;

  conv_result_t conv_results_q [$];
  conv_result_t expected_beat;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           ready_hold = 0;
  bit           calm = 1'b0;

  conv3x3_valid_bias_stream dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pix_t random_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_coef_word();
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'({$urandom, $urandom});
    case ($urandom_range(0, 7))
      0: word = '0;
      1: word = {WIN{16'h8000}};
      2: word = {WIN{16'h7FFF}};
      default: ;
    endcase
    return word;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_bias_word();
    logic [CFG_DATA_W-1:0] word;
    logic [31:0]           r;
    word = CFG_DATA_W'({$urandom, $urandom});
    r = $urandom;
    case ($urandom_range(0, 9))
      0: word[VALUE_W-1:0] = {1'b0, {(VALUE_W-1){1'b1}}} - VALUE_W'(r);
      1: word[VALUE_W-1:0] = {1'b1, {(VALUE_W-1){1'b0}}} + VALUE_W'(r);
      2, 3: ;
      default: word[VALUE_W-1:0] = {{(VALUE_W-32){r[31]}}, r};
    endcase
    return word;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_width_word();
    logic [CFG_DATA_W-1:0] word;
    int                    pick;
    word = CFG_DATA_W'({$urandom, $urandom});
    pick = $urandom_range(0, 19);
    if (pick < 13) word[LW_W-1:0] = LW_W'($urandom_range(WIN, 8));
    else if (pick < 17) word[LW_W-1:0] = LW_W'($urandom_range(9, MAX_WIDTH));
    else if (pick < 19) word[LW_W-1:0] = LW_W'($urandom_range(0, WIN - 1));
    else word[LW_W-1:0] = LW_W'($urandom_range(MAX_WIDTH + 1, (1 << LW_W) - 1));
    return word;
  endfunction

  // Advances the local model by one pixel; returns 1 when a window result is due.
  function automatic bit conv_step(input pix_t pa, input pix_t pb, input logic fs,
                                   output conv_result_t res);
    int     w, r, c;
    bit     hit;
    longint acc;
    pix_t   px [2];
    w = int'(width_q);
    if (w < WIN) w = WIN;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    px[0] = pa;
    px[1] = pb;
    if (fs) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= w) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;
    acc = longint'($signed(bias_q));
    for (int ch = 0; ch < 2; ch++) begin
      for (int m = 0; m < WIN; m++) begin
        window[ch][m][0] = window[ch][m][1];
        window[ch][m][1] = window[ch][m][2];
      end
      window[ch][0][2] = line_mem[ch][MAX_WIDTH + c];
      window[ch][1][2] = line_mem[ch][c];
      window[ch][2][2] = px[ch];
      line_mem[ch][MAX_WIDTH + c] = line_mem[ch][c];
      line_mem[ch][c] = px[ch];
      for (int m = 0; m < WIN; m++)
        for (int n = 0; n < WIN; n++)
          acc += longint'($signed(window[ch][m][n])) * longint'($signed(coefs[ch][m][n]));
    end
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (acc < SUM_MIN) acc = SUM_MIN;
    hit = (r >= 2 && c >= 2);
    res.value = acc[VALUE_W-1:0];
    res.row = COORD_W'(r - 2);
    res.col = COORD_W'(c - 2);
    res.last = (r == w - 1 && c == w - 1);
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= w) row_cnt = 0;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH %s at cycle %0d: got %0h, expected %0h", what, cycle_count, got, want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_COEF_A0, REG_COEF_A1, REG_COEF_A2: begin
        for (int n = 0; n < WIN; n++)
          coefs[0][idx - REG_COEF_A0][n] = data[COEF_W*n +: COEF_W];
      end
      REG_COEF_B0, REG_COEF_B1, REG_COEF_B2: begin
        for (int n = 0; n < WIN; n++)
          coefs[1][idx - REG_COEF_B0][n] = data[COEF_W*n +: COEF_W];
      end
      REG_BIAS: begin
        bias_q = data[VALUE_W-1:0];
      end
      REG_LINE_WIDTH: begin
        width_q = data[LW_W-1:0];
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_pixel(input pix_t pa, input pix_t pb, input logic fs);
    int           gap;
    conv_result_t res;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {pb, pa};
    s_tuser <= fs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (conv_step(pa, pb, fs, res)) conv_results_q.push_back(res);
    @(negedge clk);
  endtask

  task automatic send_run(input int count, input bit marked);
    for (int k = 0; k < count; k++)
      send_pixel(random_pixel(), random_pixel(), marked && k == 0);
  endtask

  task automatic send_flat_frame(input pix_t pa, input pix_t pb);
    for (int k = 0; k < WIN * WIN; k++)
      send_pixel(pa, pb, k == 0);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (conv_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    send_run(3 * LINE_WIDTH_RESET, 1'b1);
    wait_idle();
  endtask

  task automatic test_full_width();
    for (int k = 0; k < WIN; k++) begin
      write_reg(CFG_IDX_W'(REG_COEF_A0 + k), random_coef_word());
      write_reg(CFG_IDX_W'(REG_COEF_B0 + k), random_coef_word());
    end
    write_reg(REG_BIAS, random_bias_word());
    write_reg(REG_LINE_WIDTH, CFG_DATA_W'(MAX_WIDTH));
    send_run(4 * MAX_WIDTH, 1'b1);
    wait_idle();
  endtask

  task automatic test_extremes();
    write_reg(REG_LINE_WIDTH, CFG_DATA_W'(WIN));
    write_reg(REG_BIAS, '0);
    for (int k = 0; k < WIN; k++) begin
      write_reg(CFG_IDX_W'(REG_COEF_A0 + k), {WIN{16'h8000}});
      write_reg(CFG_IDX_W'(REG_COEF_B0 + k), {WIN{16'h7FFF}});
    end
    send_flat_frame(16'h8000, 16'h8000);
    send_flat_frame(16'h7FFF, 16'h7FFF);
    send_flat_frame(16'h8000, 16'h7FFF);
    wait_idle();
  endtask

  task automatic test_saturation();
    write_reg(REG_BIAS, {8'h5A, 40'h7F_FFFF_FFFF});
    send_flat_frame(16'h8000, 16'h0000);
    wait_idle();
    write_reg(REG_BIAS, {8'hC3, 40'h80_0000_0000});
    send_flat_frame(16'h7FFF, 16'h0000);
    wait_idle();
  endtask

  task automatic test_width_clamp();
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'({$urandom, $urandom});
    word[LW_W-1:0] = '0;
    write_reg(REG_LINE_WIDTH, word);
    send_run(WIN * WIN, 1'b1);
    wait_idle();
    word[LW_W-1:0] = LW_W'(WIN - 1);
    write_reg(REG_LINE_WIDTH, word);
    send_run(WIN * WIN, 1'b1);
    wait_idle();
    word[LW_W-1:0] = LW_W'((1 << LW_W) - 1);
    write_reg(REG_LINE_WIDTH, word);
    send_run(2 * MAX_WIDTH + 3, 1'b1);
    wait_idle();
  endtask

  task automatic test_width_shrink();
    write_reg(REG_LINE_WIDTH, CFG_DATA_W'(8));
    send_run(5 * 8 + 6, 1'b1);
    wait_idle();
    write_reg(REG_LINE_WIDTH, CFG_DATA_W'(5));
    send_run(2 * 5 * 5, 1'b0);
    wait_idle();
    write_reg(REG_LINE_WIDTH, CFG_DATA_W'(8));
    send_run(3 * 8 + 7, 1'b1);
    wait_idle();
    write_reg(REG_LINE_WIDTH, CFG_DATA_W'(6));
    send_run(2 * 6, 1'b0);
    wait_idle();
  endtask

  task automatic test_restart();
    write_reg(REG_LINE_WIDTH, CFG_DATA_W'(4));
    send_run(10, 1'b1);
    send_run(16, 1'b1);
    send_run(16, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int sent;
    int count;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      for (int k = 0; k < WIN; k++) begin
        if ($urandom_range(0, 1))
          write_reg(CFG_IDX_W'(REG_COEF_A0 + k), random_coef_word());
        if ($urandom_range(0, 1))
          write_reg(CFG_IDX_W'(REG_COEF_B0 + k), random_coef_word());
      end
      if ($urandom_range(0, 1)) write_reg(REG_BIAS, random_bias_word());
      if ($urandom_range(0, 2) != 0) write_reg(REG_LINE_WIDTH, random_width_word());
      calm = ($urandom_range(0, 3) == 0);
      count = $urandom_range(20, 150);
      if ($urandom_range(0, 4) != 0) begin
        send_run(count, $urandom_range(0, 3) != 0);
      end else begin
        for (int k = 0; k < count; k++)
          send_pixel(random_pixel(), random_pixel(), $urandom_range(0, 9) == 0);
      end
      sent += count;
      wait_idle();
    end
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      ready_hold = idle_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (conv_results_q.size() == 0) begin
        report_mismatch("beat with nothing pending", longint'(m_tdata), 0);
      end else begin
        expected_beat = conv_results_q.pop_front();
        if (m_tdata[VALUE_W-1:0] !== expected_beat.value)
          report_mismatch("conv_value", longint'(m_tdata[VALUE_W-1:0]),
                          longint'(expected_beat.value));
        if (m_tdata[ROW_LSB +: COORD_W] !== expected_beat.row)
          report_mismatch("out_row", longint'(m_tdata[ROW_LSB +: COORD_W]),
                          longint'(expected_beat.row));
        if (m_tdata[COL_LSB +: COORD_W] !== expected_beat.col)
          report_mismatch("out_col", longint'(m_tdata[COL_LSB +: COORD_W]),
                          longint'(expected_beat.col));
        if (m_tlast !== expected_beat.last)
          report_mismatch("last", longint'(m_tlast), longint'(expected_beat.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_full_width();
    test_extremes();
    test_saturation();
    test_width_clamp();
    test_width_shrink();
    test_restart();
    test_random_frames();
    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: conv3x3_valid_bias_stream.f
design/c3vb_pkg.sv
design/c3vb_line_store.sv
design/c3vb_tap_cell.sv
design/conv3x3_valid_bias_stream.sv
design/c3vb_checker.sv
verif/conv3x3_valid_bias_stream_tb.sv
